@@ sv/slt_pkg.sv @@
`default_nettype none
package slt_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and result items.
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 8;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_FIND      = 3'd2,
    OP_READ_AT   = 3'd3,
    OP_REMOVE_AT = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic ins;      // insert the request value at its sorted place
    logic del_val;  // delete the first entry equal to the request value
    logic del_pos;  // delete the entry at the request position
  } slt_ctrl_t;

  // Per-cell compare results.
  typedef struct packed {
    logic lt;        // valid entry strictly below the request value
    logic boundary;  // first cell that is not below the request value
    logic hit;       // boundary cell holds a valid entry equal to the value
  } slt_flags_t;

endpackage
`default_nettype wire

@@ sv/slt_cell.sv @@
`default_nettype none
module slt_cell #(
  parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic [DATA_WIDTH-1:0] i_value,
  input  wire logic                  i_lt_left,
  input  wire logic [DATA_WIDTH-1:0] i_entry_left,
  input  wire logic [DATA_WIDTH-1:0] i_entry_right,
  input  wire logic                  i_valid,
  input  wire logic                  i_before_pos,
  input  wire slt_pkg::slt_ctrl_t    i_ctrl,
  output logic      [DATA_WIDTH-1:0] o_entry,
  output slt_pkg::slt_flags_t        o_flags
);
  import slt_pkg::*;

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic                  lt;

  assign lt               = i_valid && (entry_r < i_value);
  assign o_flags.lt       = lt;
  assign o_flags.boundary = !lt && i_lt_left;
  assign o_flags.hit      = !lt && i_lt_left && i_valid && (entry_r == i_value);
  assign o_entry          = entry_r;

  // Insert opens a gap by shifting toward the tail; deletes close it from the right.
  always_comb begin
    entry_nxt = entry_r;
    if (i_ctrl.ins && !lt) begin
      entry_nxt = i_lt_left ? i_value : i_entry_left;
    end else if (i_ctrl.del_val && !lt) begin
      entry_nxt = i_entry_right;
    end else if (i_ctrl.del_pos && !i_before_pos) begin
      entry_nxt = i_entry_right;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

@@ sv/sorted_list_table_unit.sv @@
`default_nettype none
// Sorted table of unsigned values held in a row of DEPTH cells, one entry per cell,
// kept in ascending order with a count of valid entries. Each request item carries an
// opcode: insert (placed ahead of equal entries), remove by value, find, read at a
// 1-based position, remove at a position, and clear. Every request yields exactly one
// result item with a status, a signed position (the match, or minus the insertion
// point when absent), the read entry and the entry count after the request. A request
// is first captured into a register; then, in the execute state, every cell compares
// its entry with the request value in parallel and shifts toward or away from its
// neighbor. The next request is taken only once that execute state is done, and only
// if the result register is free or is being emptied in the same cycle; no new item is
// taken while one is in hand. Only the low DATA_WIDTH bits of the value are used.
module sorted_list_table_unit #(
  parameter int DEPTH      = slt_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0 up: opcode [2:0], value [34:3], position [41:35], zero fill.
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0 up: status [1:0], found_position [9:2], read_value [41:10],
  // entry_count [48:42], zero fill.
  output logic      [55:0] out_tdata
);
  import slt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // Request capture.
  fsm_t                  state_r, state_nxt;
  logic [OP_W-1:0]       req_op_r;
  logic [DATA_WIDTH-1:0] req_val_r;
  logic [POS_W-1:0]      req_pos_r;
  logic                  in_fire;
  logic                  exec;

  logic [DATA_WIDTH+VALUE_W-1:0] in_val_ext;

  // Table bookkeeping.
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] cnt_ext, pos_ext;
  logic          full;
  logic          pos_ok;

  // Cell row.
  logic [DATA_WIDTH-1:0] entry   [DEPTH];
  slt_flags_t            flags   [DEPTH];
  logic [DEPTH-1:0]      lt_vec;
  slt_ctrl_t             ctrl;

  // Reductions over the row.
  logic [CW-1:0]         bnd_idx;
  logic                  any_bnd;
  logic                  any_hit;
  logic [CW-1:0]         p0;
  logic [DATA_WIDTH-1:0] rd_sel;

  // Result register.
  logic                  out_tvalid_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [FPOS_W-1:0]     fpos_r, fpos_nxt;
  logic [VALUE_W-1:0]    rd_r, rd_nxt;
  logic [COUNT_W-1:0]    cnt_out_r;
  logic [CW:0]           p1;
  logic [FPOS_W-1:0]     p1_8;
  logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;

  assign in_fire    = in_tvalid && in_tready;
  assign in_val_ext = {{DATA_WIDTH{1'b0}}, in_tdata[34:3]};

  // State machine: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_fire) state_nxt = FSM_EXEC;
      FSM_EXEC: state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // State machine: outputs.
  always_comb begin
    in_tready = 1'b0;
    exec      = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_tready = !out_tvalid_r || out_tready;
      FSM_EXEC: exec = 1'b1;
      default:  exec = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op_r  <= in_tdata[2:0];
      req_val_r <= in_val_ext[DATA_WIDTH-1:0];
      req_pos_r <= in_tdata[41:35];
    end
  end

  assign cnt_ext = PW'(count_r);
  assign pos_ext = PW'(req_pos_r);
  assign full    = (cnt_ext == PW'(DEPTH));
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

  // The row of cells. Cell 0 sees an always-below left neighbor so that an
  // insert ahead of every entry lands there; the last cell refills from itself.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                  lt_left;
      logic [DATA_WIDTH-1:0] ent_left;
      logic [DATA_WIDTH-1:0] ent_right;
      logic                  valid;
      logic                  before_pos;

      if (gi == 0) begin : g_first
        assign lt_left  = 1'b1;
        assign ent_left = entry[gi];
      end else begin : g_mid
        assign lt_left  = lt_vec[gi-1];
        assign ent_left = entry[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign ent_right = entry[gi];
      end else begin : g_inner
        assign ent_right = entry[gi+1];
      end

      assign valid      = PW'(gi) < cnt_ext;
      assign before_pos = PW'(gi + 1) < pos_ext;
      assign lt_vec[gi] = flags[gi].lt;

      slt_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk           (clk),
        .i_value       (req_val_r),
        .i_lt_left     (lt_left),
        .i_entry_left  (ent_left),
        .i_entry_right (ent_right),
        .i_valid       (valid),
        .i_before_pos  (before_pos),
        .i_ctrl        (ctrl),
        .o_entry       (entry[gi]),
        .o_flags       (flags[gi])
      );
    end
  endgenerate

  // The compare flags form a thermometer, so at most one cell marks the boundary.
  always_comb begin
    bnd_idx = '0;
    any_bnd = 1'b0;
    any_hit = 1'b0;
    rd_sel  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (flags[i].boundary) begin
        bnd_idx = bnd_idx | CW'(i);
      end
      any_bnd = any_bnd | flags[i].boundary;
      any_hit = any_hit | flags[i].hit;
      if (PW'(i + 1) == pos_ext) begin
        rd_sel = rd_sel | entry[i];
      end
    end
  end

  // With every cell valid and below the value, the value belongs past the end.
  assign p0   = any_bnd ? bnd_idx : CW'(DEPTH);
  assign p1   = {1'b0, p0} + (CW + 1)'(1);
  assign p1_8 = FPOS_W'(p1);

  always_comb begin
    ctrl.ins     = exec && (req_op_r == OP_INSERT) && !full;
    ctrl.del_val = exec && (req_op_r == OP_REMOVE) && any_hit;
    ctrl.del_pos = exec && (req_op_r == OP_REMOVE_AT) && pos_ok;
  end

  // Result fields and the new count.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    fpos_nxt   = '0;
    rd_ext     = '0;
    case (req_op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          fpos_nxt  = p1_8;
        end
      end
      OP_REMOVE, OP_FIND: begin
        if (any_hit) begin
          fpos_nxt = p1_8;
          if (req_op_r == OP_REMOVE) begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          status_nxt = ST_NOT_FOUND;
          fpos_nxt   = FPOS_W'(0) - p1_8;
        end
      end
      OP_READ_AT: begin
        if (pos_ok) begin
          rd_ext = {{VALUE_W{1'b0}}, rd_sel};
        end else begin
          status_nxt = ST_BAD_POS;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_ok) begin
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = ST_BAD_POS;
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
    rd_nxt = rd_ext[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (exec) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_r  <= status_nxt;
      fpos_r    <= fpos_nxt;
      rd_r      <= rd_nxt;
      cnt_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, cnt_out_r, rd_r, fpos_r, status_r};

  // A captured request is executed in the very next cycle and then reported.
  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == FSM_EXEC) && !in_tready)
    else $error("request not executed after capture");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_tvalid)
    else $error("no result after execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= PW'(DEPTH))
    else $error("entry count above depth");

  a_hit_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && any_hit) |-> any_bnd)
    else $error("match found away from the sorted boundary");

endmodule
`default_nettype wire

@@ tb/slt_result_checker.sv @@
// Watches both channels of the sorted table. Each accepted request item is applied to a
// private copy of the table, and the predicted result item is queued. Each accepted
// result item is compared field by field with the oldest prediction.
module slt_result_checker
  import slt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  output int          fail_count,
  output int          results_pending,
  output int          results_checked,
  output int          full_refusals,
  output int          peak_entries
);

  localparam int SLOTS = DEPTH_DEF;

  typedef struct {
    status_t     status;
    logic [7:0]  found_pos;
    logic [31:0] read_val;
    logic [6:0]  entries;
  } slt_result_t;

  logic [31:0] table_mirror [SLOTS];
  int          mirror_count;
  slt_result_t result_q [$];

  // 1-based index of the first entry not below v; hit tells whether it equals v.
  function automatic int seek(input logic [31:0] v, output logic hit);
    int p;
    p = 0;
    while (p < mirror_count && v > table_mirror[p]) p++;
    hit = (p < mirror_count) && (table_mirror[p] == v);
    return p + 1;
  endfunction

  function automatic void drop_entry(input int idx);
    for (int i = idx; i + 1 < mirror_count; i++) table_mirror[i] = table_mirror[i + 1];
    mirror_count--;
  endfunction

  function automatic slt_result_t apply_request(input logic [2:0] op, input logic [31:0] v,
                                                input logic [6:0] pos);
    slt_result_t r;
    int          p;
    int          fp;
    logic        hit;
    r.status   = ST_OK;
    r.read_val = '0;
    fp         = 0;
    case (op)
      OP_INSERT: begin
        if (mirror_count >= SLOTS) begin
          r.status = ST_FULL;
          full_refusals++;
        end else begin
          p = seek(v, hit);
          for (int i = mirror_count; i >= p; i--) table_mirror[i] = table_mirror[i - 1];
          table_mirror[p - 1] = v;
          mirror_count++;
          fp = p;
        end
      end
      OP_REMOVE, OP_FIND: begin
        p = seek(v, hit);
        if (hit) begin
          fp = p;
          if (op == OP_REMOVE) drop_entry(p - 1);
        end else begin
          r.status = ST_NOT_FOUND;
          fp = -p;
        end
      end
      OP_READ_AT, OP_REMOVE_AT: begin
        if (pos < 1 || pos > mirror_count) begin
          r.status = ST_BAD_POS;
        end else if (op == OP_READ_AT) begin
          r.read_val = table_mirror[pos - 1];
        end else begin
          drop_entry(pos - 1);
        end
      end
      OP_CLEAR: mirror_count = 0;
      default: ;
    endcase
    r.found_pos = fp[7:0];
    r.entries   = mirror_count[6:0];
    if (mirror_count > peak_entries) peak_entries = mirror_count;
    return r;
  endfunction

  always @(posedge clk) begin
    slt_result_t want;
    if (!rst_n) begin
      result_q.delete();
      mirror_count    = 0;
      fail_count      = 0;
      results_checked = 0;
      full_refusals   = 0;
      peak_entries    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result item with no request outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          results_checked++;
          if (out_tdata[1:0] != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
            fail_count++;
          end
          if (out_tdata[9:2] != want.found_pos) begin
            $error("found_position: expected %0d, got %0d",
                   $signed(want.found_pos), $signed(out_tdata[9:2]));
            fail_count++;
          end
          if (out_tdata[41:10] != want.read_val) begin
            $error("read_value: expected %h, got %h", want.read_val, out_tdata[41:10]);
            fail_count++;
          end
          if (out_tdata[48:42] != want.entries) begin
            $error("entry_count: expected %0d, got %0d", want.entries, out_tdata[48:42]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        result_q.push_back(apply_request(in_tdata[2:0], in_tdata[34:3], in_tdata[41:35]));
    end
    results_pending = result_q.size();
  end

endmodule

@@ tb/sorted_list_table_unit_tb.sv @@
// Top of the sorted table testbench. This module only generates traffic and gives the
// verdict; all prediction and comparison lives in slt_result_checker, which sits beside
// the block and watches both channels.
module sorted_list_table_unit_tb;
  import slt_pkg::*;

  // Opcodes the block does not define. They must still produce one plain result item.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS    = 1625;
  localparam int PHASE_LEN       = 150;
  localparam int SQUEEZE_AT      = 700;
  localparam int HOLD_OFF_CYCLES = 400;
  // The slowest correct run is about 1650 items, each with the longest sender gap and
  // receiver stall on top of the block's own time; the limit is several times that run.
  localparam int CYCLE_LIMIT     = 800000;

  // Traffic mixes for the random part. GROW pushes the table to full and keeps hitting
  // it there, SHRINK drains it down to empty, CHURN stirs everything including clear.
  typedef enum {GROW, CHURN, SHRINK} traffic_mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // opcode [2:0], value [34:3], position [41:35], zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;      // status [1:0], found_position [9:2], read_value [41:10],
                               // entry_count [48:42], zero fill

  int fail_count;
  int results_pending;
  int results_checked;
  int full_refusals;
  int peak_entries;

  int   items_sent = 0;
  int   cycle_count = 0;
  logic squeeze_req = 1'b0;
  logic sender_eager = 1'b0;

  always #10 clk = ~clk;

  sorted_list_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  slt_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .results_checked (results_checked),
    .full_refusals   (full_refusals),
    .peak_entries    (peak_entries)
  );

  // Idle lengths shared by both sides: mostly none, now and then a long one so that
  // gaps land on every phase of the block's operation.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values cluster just above a per-phase base so that equal entries, hits and near
  // misses are common, with fully random words and the unsigned extremes mixed in.
  function automatic logic [31:0] pick_value(input logic [31:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return base + $urandom_range(0, 31);
    if (r < 90) return $urandom;
    if (r < 94) return 32'h0000_0000;
    if (r < 97) return 32'hFFFF_FFFF;
    return 32'h8000_0000;
  endfunction

  // Positions mostly fall in or just outside the legal 1..64 range; a few use the whole
  // seven-bit field so that every position bit toggles.
  function automatic logic [6:0] pick_position();
    if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, 66));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [2:0] pick_opcode(input traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      GROW: begin
        if (r < 75) return OP_INSERT;
        if (r < 85) return OP_FIND;
        if (r < 95) return OP_READ_AT;
        return OP_REMOVE;
      end
      SHRINK: begin
        if (r < 30) return OP_REMOVE;
        if (r < 60) return OP_REMOVE_AT;
        if (r < 75) return OP_FIND;
        if (r < 90) return OP_READ_AT;
        return OP_INSERT;
      end
      default: begin
        if (r < 35) return OP_INSERT;
        if (r < 50) return OP_REMOVE;
        if (r < 65) return OP_FIND;
        if (r < 80) return OP_READ_AT;
        if (r < 93) return OP_REMOVE_AT;
        if (r < 96) return OP_CLEAR;
        return (r < 98) ? OP_SPARE_LO : OP_SPARE_HI;
      end
    endcase
  endfunction

  // Offers one request item and returns once it has been taken. Data changes only on
  // the falling edge, and in_tready is looked at on the rising edge. When no idle gap
  // is drawn, in_tvalid simply stays high into the next item.
  task automatic issue(input logic [2:0] op, input logic [31:0] v, input logic [6:0] pos);
    int gap;
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, pos, v, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    // Partway through, ask the receiver for one long hold-off while requests keep coming,
    // so the result register fills and the block has to stall its input.
    if (items_sent == SQUEEZE_AT) squeeze_req = 1'b1;
  endtask

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: alternates ready stretches and stalls. Long ready runs give stretches
  // with no back pressure at all; the single long hold-off is counted down here.
  initial begin : result_drain
    int   stall_left;
    int   run_left;
    logic squeezed;
    stall_left = 0;
    run_left   = 0;
    squeezed   = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed   = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        if (run_left == 0) begin
          run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 30);
          stall_left = pick_gap();
        end
        out_tready <= 1'b1;
        run_left--;
      end
    end
  end

  initial begin : stimulus
    traffic_mix_t mix;
    logic [31:0]  base;
    logic [2:0]   op;
    int           directed_items;

    // Synchronous reset, released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Empty-table cases first: find and remove of an absent value, and
    // position requests with nothing stored.
    issue(OP_FIND,      32'd5,         7'd0);
    issue(OP_REMOVE,    32'd5,         7'd0);
    issue(OP_READ_AT,   32'd0,         7'd1);
    issue(OP_REMOVE_AT, 32'd0,         7'd0);
    // Build 0, 7, 7, max: the extremes, and a duplicate that must land ahead of its twin.
    issue(OP_INSERT,    32'hFFFF_FFFF, 7'd0);
    issue(OP_INSERT,    32'h0000_0000, 7'd0);
    issue(OP_INSERT,    32'd7,         7'd0);
    issue(OP_INSERT,    32'd7,         7'd0);
    issue(OP_FIND,      32'd7,         7'd0);
    issue(OP_FIND,      32'd8,         7'd0);
    issue(OP_FIND,      32'hFFFF_FFFF, 7'd0);
    issue(OP_READ_AT,   32'd0,         7'd4);
    // Positions out of range: zero, just above the count, and the top of the field.
    issue(OP_READ_AT,   32'd0,         7'd0);
    issue(OP_READ_AT,   32'd0,         7'd5);
    issue(OP_READ_AT,   32'd0,         7'd127);
    issue(OP_REMOVE_AT, 32'd0,         7'd64);
    issue(OP_REMOVE,    32'hFFFF_FFFE, 7'd0);
    issue(OP_REMOVE,    32'd7,         7'd0);
    issue(OP_REMOVE_AT, 32'd0,         7'd1);
    // Undefined opcodes are answered with a plain result and leave the table alone.
    issue(OP_SPARE_LO,  32'h5A5A_A5A5, 7'd42);
    issue(OP_SPARE_HI,  32'hA5A5_5A5A, 7'd85);
    issue(OP_CLEAR,     32'd0,         7'd0);
    issue(OP_READ_AT,   32'd0,         7'd1);
    // Unsigned ordering: the top bit set must sort above a value just below it.
    issue(OP_INSERT,    32'h8000_0000, 7'd0);
    issue(OP_FIND,      32'h7FFF_FFFF, 7'd0);
    directed_items = items_sent;

    // Random part, in phases cycling through grow, churn, shrink and churn again. Each
    // phase picks a new value base and sometimes sends back to back without gaps.
    mix  = GROW;
    base = '0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        case ((k / PHASE_LEN) % 4)
          0:       mix = GROW;
          2:       mix = SHRINK;
          default: mix = CHURN;
        endcase
        base         = $urandom;
        sender_eager = ($urandom_range(0, 3) == 0);
      end
      op = pick_opcode(mix);
      issue(op, pick_value(base), pick_position());
    end

    // All requests are in; stop offering and let the outstanding results drain.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    // Keep the clock running so that any stray extra result item still shows up.
    repeat (10) @(posedge clk);

    $display("Run summary: %0d requests (%0d directed), %0d results compared.",
             items_sent, directed_items, results_checked);
    $display("Table peaked at %0d entries, %0d inserts refused as full, one %0d-cycle stall.",
             peak_entries, full_refusals, HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/slt_pkg.sv
sv/slt_cell.sv
sv/sorted_list_table_unit.sv
tb/slt_result_checker.sv
tb/sorted_list_table_unit_tb.sv
